// ===== hw/rtl/kmr_pkg.sv =====
// shared types and constants for the keystroke macro recorder
package kmr_pkg;

    localparam int unsigned DEPTH_DEFAULT = 256;
    localparam int unsigned KEY_W         = 16;
    localparam int unsigned ENTRY_W       = 2 * KEY_W;
    localparam int unsigned REPEAT_W      = 4;

    localparam logic [7:0]          DIGIT_ZERO     = 8'h30;
    localparam logic [7:0]          DIGIT_NINE     = 8'h39;
    localparam logic [REPEAT_W-1:0] REPEAT_DEFAULT = 4'd1;

    typedef enum logic [2:0] {
        OP_KEY        = 3'd0,
        OP_REC_START  = 3'd1,
        OP_REC_STOP   = 3'd2,
        OP_PLAY_START = 3'd3,
        OP_PLAY_TICK  = 3'd4
    } kmr_op_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_NOT_DIGIT = 2'd1,
        ERR_FULL      = 2'd2
    } kmr_err_t;

    typedef struct packed {
        logic     pass_key;
        logic     key_valid;
        kmr_err_t error_code;
        logic     recording;
        logic     playing;
    } kmr_result_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } kmr_mem_ctl_t;

endpackage

// ===== hw/rtl/kmr_store.sv =====
// key store memory, one write port and one registered read port
module kmr_store #(
    parameter int unsigned DEPTH = kmr_pkg::DEPTH_DEFAULT,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  kmr_pkg::kmr_mem_ctl_t       mem_ctl,
    input  logic [AW-1:0]               wr_addr,
    input  logic [kmr_pkg::ENTRY_W-1:0] wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic [kmr_pkg::ENTRY_W-1:0] rd_data
);
    import kmr_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/kmr_ctrl.sv =====
// record and playback control state with store access requests
module kmr_ctrl #(
    parameter int unsigned DEPTH = kmr_pkg::DEPTH_DEFAULT,
    parameter int unsigned AW    = $clog2(DEPTH),
    parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [2:0]                  opcode,
    input  logic [kmr_pkg::KEY_W-1:0]   key_state,
    input  logic [kmr_pkg::KEY_W-1:0]   key_code,
    output kmr_pkg::kmr_result_t        result,
    output kmr_pkg::kmr_mem_ctl_t       mem_ctl,
    output logic [AW-1:0]               wr_addr,
    output logic [kmr_pkg::ENTRY_W-1:0] wr_data,
    output logic [AW-1:0]               rd_addr
);
    import kmr_pkg::*;

    logic                record_active_reg, record_active_next;
    logic                play_active_reg, play_active_next;
    logic                store_present_reg, store_present_next;
    logic                awaiting_reg, awaiting_next;
    logic [CW-1:0]       stored_count_reg, stored_count_next;
    logic [REPEAT_W-1:0] repeat_total_reg, repeat_total_next;
    logic [CW-1:0]       play_position_reg, play_position_next;
    logic [REPEAT_W-1:0] pass_number_reg, pass_number_next;

    logic [7:0] key_char;
    logic       is_digit;

    assign key_char = key_code[7:0];
    assign is_digit = (key_char >= DIGIT_ZERO) && (key_char <= DIGIT_NINE);
    assign wr_addr  = stored_count_reg[AW-1:0];
    assign wr_data  = {key_state, key_code};
    assign rd_addr  = play_position_reg[AW-1:0];

    always_comb
    begin
        record_active_next = record_active_reg;
        play_active_next   = play_active_reg;
        store_present_next = store_present_reg;
        awaiting_next      = awaiting_reg;
        stored_count_next  = stored_count_reg;
        repeat_total_next  = repeat_total_reg;
        play_position_next = play_position_reg;
        pass_number_next   = pass_number_reg;
        result             = '0;
        mem_ctl            = '0;

        unique case (kmr_op_t'(opcode))
            OP_KEY:
            begin
                if (!record_active_reg)
                begin
                    result.pass_key = 1'b1;
                end
                else if (awaiting_reg)
                begin
                    if (is_digit)
                    begin
                        repeat_total_next = key_char[REPEAT_W-1:0];
                        awaiting_next     = 1'b0;
                    end
                    else
                    begin
                        record_active_next = 1'b0;
                        result.error_code  = ERR_NOT_DIGIT;
                    end
                end
                else
                begin
                    result.pass_key = 1'b1;
                    if (stored_count_reg < CW'(DEPTH))
                    begin
                        mem_ctl.wr_en     = accept;
                        stored_count_next = stored_count_reg + CW'(1);
                    end
                    else
                    begin
                        record_active_next = 1'b0;
                        result.error_code  = ERR_FULL;
                    end
                end
            end
            OP_REC_START:
            begin
                store_present_next = 1'b1;
                record_active_next = 1'b1;
                play_active_next   = 1'b0;
                awaiting_next      = 1'b1;
                stored_count_next  = '0;
                repeat_total_next  = REPEAT_DEFAULT;
                play_position_next = '0;
            end
            OP_REC_STOP:
            begin
                record_active_next = 1'b0;
            end
            OP_PLAY_START:
            begin
                if (store_present_reg)
                begin
                    play_position_next = '0;
                    pass_number_next   = '0;
                    record_active_next = 1'b0;
                    play_active_next   = 1'b1;
                end
            end
            OP_PLAY_TICK:
            begin
                if (play_active_reg)
                begin
                    if (pass_number_reg < repeat_total_reg)
                    begin
                        if (play_position_reg < stored_count_reg)
                        begin
                            mem_ctl.rd_en      = accept;
                            result.key_valid   = 1'b1;
                            play_position_next = play_position_reg + CW'(1);
                        end
                        else
                        begin
                            play_position_next = '0;
                            pass_number_next   = pass_number_reg + REPEAT_W'(1);
                        end
                    end
                    else
                    begin
                        play_active_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        result.recording = record_active_next;
        result.playing   = play_active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_active_reg <= 1'b0;
            play_active_reg   <= 1'b0;
            store_present_reg <= 1'b0;
            awaiting_reg      <= 1'b0;
            stored_count_reg  <= '0;
            repeat_total_reg  <= REPEAT_DEFAULT;
            play_position_reg <= '0;
            pass_number_reg   <= '0;
        end
        else if (accept)
        begin
            record_active_reg <= record_active_next;
            play_active_reg   <= play_active_next;
            store_present_reg <= store_present_next;
            awaiting_reg      <= awaiting_next;
            stored_count_reg  <= stored_count_next;
            repeat_total_reg  <= repeat_total_next;
            play_position_reg <= play_position_next;
            pass_number_reg   <= pass_number_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_count_reg <= CW'(DEPTH))
        else $error("stored count beyond store depth");

    a_position_bound: assert property (@(posedge clk) disable iff (!rst_n)
        play_position_reg <= stored_count_reg)
        else $error("play position beyond stored count");

    a_pass_key_op: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (opcode != OP_KEY) |-> !result.pass_key)
        else $error("pass_key set for a non key request");

endmodule

// ===== hw/rtl/keystroke_macro_recorder_top.sv =====
// top level of the keystroke macro recorder: request pipe, store and result register
// Control state updates at acceptance, a play tick launches its key store read at the
// acceptance edge, and the result passes through the pending slot (with the store read)
// and then the result register before it is offered. With the output drained every
// cycle one request is taken per cycle; a stalled result holds the result register and
// the pending slot, so at most two requests are in flight before the input stalls. The
// store has no reset and needs no clearing pass.
module keystroke_macro_recorder_top #(
    parameter int unsigned DEPTH = kmr_pkg::DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                opcode,
    input  logic [kmr_pkg::KEY_W-1:0] key_state,
    input  logic [kmr_pkg::KEY_W-1:0] key_code,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      pass_key,
    output logic                      key_valid,
    output logic [kmr_pkg::KEY_W-1:0] out_key_state,
    output logic [kmr_pkg::KEY_W-1:0] out_key_code,
    output logic [1:0]                error_code,
    output logic                      recording,
    output logic                      playing
);
    import kmr_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic               accept;
    kmr_result_t        result;
    kmr_mem_ctl_t       mem_ctl;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    logic               pend_valid_reg, pend_valid_next;
    kmr_result_t        pend_result_reg;
    logic               out_valid_reg, out_valid_next;
    kmr_result_t        out_result_reg;
    logic [ENTRY_W-1:0] out_entry_reg;
    logic               pend_move;

    assign pend_move = pend_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !pend_valid_reg || pend_move;
    assign accept    = in_valid && in_ready;

    kmr_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .opcode    (opcode),
        .key_state (key_state),
        .key_code  (key_code),
        .result    (result),
        .mem_ctl   (mem_ctl),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr)
    );

    kmr_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        pend_valid_next = accept || (pend_valid_reg && !pend_move);
        out_valid_next  = pend_move || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_result_reg <= result;
        end
        if (pend_move)
        begin
            out_result_reg <= pend_result_reg;
            out_entry_reg  <= pend_result_reg.key_valid ? rd_data : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pass_key      = out_result_reg.pass_key;
    assign key_valid     = out_result_reg.key_valid;
    assign out_key_state = out_entry_reg[ENTRY_W-1:KEY_W];
    assign out_key_code  = out_entry_reg[KEY_W-1:0];
    assign error_code    = out_result_reg.error_code;
    assign recording     = out_result_reg.recording;
    assign playing       = out_result_reg.playing;

    a_empty_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !key_valid |-> (out_key_state == '0) && (out_key_code == '0))
        else $error("played key fields set without a played key");

    a_modes_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(recording && playing))
        else $error("recording and playback both active");

    a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code != ERR_NONE) |-> !recording && !key_valid)
        else $error("error reported while recording continues");

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the keystroke macro recorder
module tb_top;

    import kmr_pkg::*;

    localparam int unsigned DEPTH        = DEPTH_DEFAULT;
    localparam int unsigned AW           = $clog2(DEPTH);
    localparam int          NUM_DIR      = 27;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          BURST_CYCLES = 96;
    localparam int          MAX_PRINTS   = 40;
    localparam logic [2:0]  OP_UNDEF_FIRST = 3'd5;
    localparam logic [2:0]  OP_UNDEF_LAST  = 3'd7;

    typedef struct packed {
        logic          pass_key;
        logic          key_valid;
        logic [15:0]   out_key_state;
        logic [15:0]   out_key_code;
        logic [1:0]    error_code;
        logic          recording;
        logic          playing;
    } macro_result_t;

    typedef struct packed {
        logic [2:0]    op;
        logic [15:0]   kst;
        logic [15:0]   kc;
        logic          typed;
        macro_result_t res;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        opcode;
    logic [KEY_W-1:0]  key_state;
    logic [KEY_W-1:0]  key_code;
    logic              out_valid;
    logic              out_ready;
    logic              pass_key;
    logic              key_valid;
    logic [KEY_W-1:0]  out_key_state;
    logic [KEY_W-1:0]  out_key_code;
    logic [1:0]        error_code;
    logic              recording;
    logic              playing;

    // predictor state
    logic [31:0]       macro_mem [DEPTH];
    logic              rec_on;
    logic              play_on;
    logic              have_macro;
    logic              want_digit;
    int unsigned       n_stored;
    int unsigned       play_idx;
    logic [3:0]        repeats;
    logic [3:0]        pass_idx;

    macro_result_t     pending_results [$];
    stim_row_t         dir_rows [NUM_DIR];
    int                send_pct;
    int                recv_pct;
    bit                stall_burst_req;
    int                items_sent;
    int                results_checked;
    int                keys_played;
    int                overflows;
    int                mismatches;

    keystroke_macro_recorder_top #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .key_state     (key_state),
        .key_code      (key_code),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pass_key      (pass_key),
        .key_valid     (key_valid),
        .out_key_state (out_key_state),
        .out_key_code  (out_key_code),
        .error_code    (error_code),
        .recording     (recording),
        .playing       (playing)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic macro_result_t macro_step(input logic [2:0] op, input logic [15:0] kst,
                                                 input logic [15:0] kc);
        macro_result_t r;
        logic [7:0]    digit;
        r = '0;
        case (op)
            OP_KEY:
            begin
                if (!rec_on)
                    r.pass_key = 1'b1;
                else if (want_digit)
                begin
                    if (kc[7:0] >= DIGIT_ZERO && kc[7:0] <= DIGIT_NINE)
                    begin
                        digit      = kc[7:0] - DIGIT_ZERO;
                        repeats    = digit[3:0];
                        want_digit = 1'b0;
                    end
                    else
                    begin
                        rec_on       = 1'b0;
                        r.error_code = ERR_NOT_DIGIT;
                    end
                end
                else
                begin
                    r.pass_key = 1'b1;
                    if (n_stored < DEPTH)
                    begin
                        macro_mem[n_stored[AW-1:0]] = {kst, kc};
                        n_stored++;
                    end
                    else
                    begin
                        rec_on       = 1'b0;
                        r.error_code = ERR_FULL;
                        overflows++;
                    end
                end
            end
            OP_REC_START:
            begin
                have_macro = 1'b1;
                rec_on     = 1'b1;
                play_on    = 1'b0;
                want_digit = 1'b1;
                n_stored   = 0;
                repeats    = REPEAT_DEFAULT;
                play_idx   = 0;
            end
            OP_REC_STOP:
                rec_on = 1'b0;
            OP_PLAY_START:
            begin
                if (have_macro)
                begin
                    play_idx = 0;
                    pass_idx = '0;
                    rec_on   = 1'b0;
                    play_on  = 1'b1;
                end
            end
            OP_PLAY_TICK:
            begin
                if (play_on)
                begin
                    if (pass_idx < repeats)
                    begin
                        if (play_idx < n_stored)
                        begin
                            {r.out_key_state, r.out_key_code} = macro_mem[play_idx[AW-1:0]];
                            r.key_valid = 1'b1;
                            play_idx++;
                        end
                        else
                        begin
                            play_idx = 0;
                            pass_idx = pass_idx + 4'd1;
                        end
                    end
                    else
                        play_on = 1'b0;
                end
            end
            default:
                r = '0;
        endcase
        r.recording = rec_on;
        r.playing   = play_on;
        return r;
    endfunction

    function automatic logic [15:0] rand16();
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at %0t, result %0d: %s got %h, want %h",
                     $time, results_checked, what, got, want);
    endtask

    task automatic send_request(input logic [2:0] op, input logic [15:0] kst,
                                input logic [15:0] kc, input bit use_typed = 1'b0,
                                input macro_result_t typed_res = '0);
        int            gap;
        macro_result_t predicted;
        gap = 0;
        while ($urandom_range(0, 99) < send_pct && gap < 8)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        key_state <= kst;
        key_code  <= kc;
        do @(posedge clk); while (!in_ready);
        predicted = macro_step(op, kst, kc);
        pending_results.push_back(use_typed ? typed_res : predicted);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_noise();
        logic [2:0]  op;
        logic [15:0] kc;
        op = 3'($urandom_range(OP_KEY, OP_UNDEF_LAST));
        kc = rand16();
        if ($urandom_range(0, 2) == 0)
            kc[7:0] = DIGIT_ZERO + 8'($urandom_range(0, 9));
        send_request(op, rand16(), kc);
    endtask

    task automatic record_and_play(input int n_keys, input bit fill);
        logic [7:0] ch;
        logic [7:0] hi;
        int         ticks;
        send_request(OP_REC_START, rand16(), rand16());
        hi = 8'($urandom_range(0, 255));
        if (fill)
            ch = DIGIT_ZERO + 8'd1;
        else if ($urandom_range(0, 9) != 0)
            ch = DIGIT_ZERO + 8'($urandom_range(0, 9));
        else
        begin
            ch = 8'($urandom_range(0, 255));
            while (ch >= DIGIT_ZERO && ch <= DIGIT_NINE)
                ch = 8'($urandom_range(0, 255));
        end
        send_request(OP_KEY, rand16(), {hi, ch});
        for (int k = 0; k < n_keys; k++)
        begin
            if (!fill && $urandom_range(0, 19) == 0)
                send_noise();
            send_request(OP_KEY, rand16(), rand16());
        end
        if ($urandom_range(0, 1) == 1)
            send_request(OP_REC_STOP, rand16(), rand16());
        send_request(OP_PLAY_START, rand16(), rand16());
        ticks = play_on ? int'(repeats) * (int'(n_stored) + 1) + 1 : 1;
        if (!fill && $urandom_range(0, 9) == 0)
            ticks = int'($urandom_range(0, ticks - 1));
        else
            ticks += int'($urandom_range(0, 2));
        repeat (ticks)
            send_request(OP_PLAY_TICK, rand16(), rand16());
    endtask

    task automatic run_phase(input int snd, input int rcv, input int goal, input bit burst);
        int target;
        send_pct = snd;
        recv_pct = rcv;
        target   = items_sent + goal;
        if (burst)
        begin
            stall_burst_req = 1'b1;
            record_and_play(DEPTH + 2, 1'b1);
        end
        while (items_sent < target)
        begin
            if ($urandom_range(0, 99) < 85)
                record_and_play($urandom_range(0, 8), 1'b0);
            else
                send_noise();
        end
        drain();
    endtask

    initial
    begin : stimulus
        rec_on          = 1'b0;
        play_on         = 1'b0;
        have_macro      = 1'b0;
        want_digit      = 1'b0;
        n_stored        = 0;
        repeats         = REPEAT_DEFAULT;
        play_idx        = 0;
        pass_idx        = '0;
        send_pct        = 0;
        recv_pct        = 0;
        stall_burst_req = 1'b0;
        items_sent      = 0;
        results_checked = 0;
        keys_played     = 0;
        overflows       = 0;
        mismatches      = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        opcode    <= OP_KEY;
        key_state <= '0;
        key_code  <= '0;

        // typed rows: {pass_key, key_valid, state, code, error, recording, playing}
        dir_rows = '{
            '{OP_PLAY_TICK,   16'h0000, 16'h0000, 1'b1,
              '{1'b0, 1'b0, 16'h0, 16'h0, ERR_NONE, 1'b0, 1'b0}},
            '{OP_PLAY_START,  16'h0000, 16'h0000, 1'b1,
              '{1'b0, 1'b0, 16'h0, 16'h0, ERR_NONE, 1'b0, 1'b0}},
            '{OP_KEY,         16'hFFFF, 16'hFFFF, 1'b1,
              '{1'b1, 1'b0, 16'h0, 16'h0, ERR_NONE, 1'b0, 1'b0}},
            '{OP_REC_STOP,    16'h0000, 16'h0000, 1'b1,
              '{1'b0, 1'b0, 16'h0, 16'h0, ERR_NONE, 1'b0, 1'b0}},
            '{OP_UNDEF_FIRST, 16'hFFFF, 16'hFFFF, 1'b1,
              '{1'b0, 1'b0, 16'h0, 16'h0, ERR_NONE, 1'b0, 1'b0}},
            '{OP_UNDEF_LAST,  16'hFFFF, 16'hFFFF, 1'b1,
              '{1'b0, 1'b0, 16'h0, 16'h0, ERR_NONE, 1'b0, 1'b0}},
            '{OP_REC_START,   16'h0000, 16'h0000, 1'b1,
              '{1'b0, 1'b0, 16'h0, 16'h0, ERR_NONE, 1'b1, 1'b0}},
            '{OP_KEY,         16'h0000, 16'h002F, 1'b1,
              '{1'b0, 1'b0, 16'h0, 16'h0, ERR_NOT_DIGIT, 1'b0, 1'b0}},
            '{OP_REC_START,   16'hFFFF, 16'hFFFF, 1'b1,
              '{1'b0, 1'b0, 16'h0, 16'h0, ERR_NONE, 1'b1, 1'b0}},
            '{OP_KEY,         16'hFFFF, 16'h003A, 1'b1,
              '{1'b0, 1'b0, 16'h0, 16'h0, ERR_NOT_DIGIT, 1'b0, 1'b0}},
            '{OP_REC_START,   16'h0000, 16'h0000, 1'b0, '0},
            '{OP_KEY,         16'h0000, 16'hFF32, 1'b0, '0},
            '{OP_KEY,         16'hFFFF, 16'hFFFF, 1'b0, '0},
            '{OP_KEY,         16'h0000, 16'h0000, 1'b0, '0},
            '{OP_REC_STOP,    16'h0000, 16'h0000, 1'b0, '0},
            '{OP_PLAY_START,  16'h0000, 16'h0000, 1'b0, '0},
            '{OP_PLAY_TICK,   16'h0000, 16'h0000, 1'b0, '0},
            '{OP_PLAY_TICK,   16'h0000, 16'h0000, 1'b0, '0},
            '{OP_PLAY_TICK,   16'h0000, 16'h0000, 1'b0, '0},
            '{OP_PLAY_TICK,   16'h0000, 16'h0000, 1'b0, '0},
            '{OP_PLAY_TICK,   16'h0000, 16'h0000, 1'b0, '0},
            '{OP_PLAY_TICK,   16'h0000, 16'h0000, 1'b0, '0},
            '{OP_PLAY_TICK,   16'h0000, 16'h0000, 1'b0, '0},
            '{OP_REC_START,   16'h0000, 16'h0000, 1'b0, '0},
            '{OP_KEY,         16'h0000, 16'h0030, 1'b0, '0},
            '{OP_PLAY_START,  16'h0000, 16'h0000, 1'b0, '0},
            '{OP_PLAY_TICK,   16'h0000, 16'h0000, 1'b0, '0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIR; i++)
            send_request(dir_rows[i].op, dir_rows[i].kst, dir_rows[i].kc,
                         dir_rows[i].typed, dir_rows[i].res);
        drain();

        run_phase(0, 0, 230, 1'b0);
        run_phase(50, 0, 230, 1'b0);
        run_phase(0, 50, 450, 1'b1);
        run_phase(26, 26, 230, 1'b0);

        repeat (8) @(posedge clk);
        $display("covered %0d requests: directed table, random macros, four idle/stall mixes",
                 items_sent);
        $display("%0d results checked, %0d played keys, %0d store overflows, %0d mismatches",
                 results_checked, keys_played, overflows, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : result_sink
        int            stall_left;
        macro_result_t want;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with no request pending", '0, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (pass_key !== want.pass_key)
                        report_mismatch("pass_key", pass_key, want.pass_key);
                    if (key_valid !== want.key_valid)
                        report_mismatch("key_valid", key_valid, want.key_valid);
                    if (out_key_state !== want.out_key_state)
                        report_mismatch("out_key_state", out_key_state, want.out_key_state);
                    if (out_key_code !== want.out_key_code)
                        report_mismatch("out_key_code", out_key_code, want.out_key_code);
                    if (error_code !== want.error_code)
                        report_mismatch("error_code", error_code, want.error_code);
                    if (recording !== want.recording)
                        report_mismatch("recording", recording, want.recording);
                    if (playing !== want.playing)
                        report_mismatch("playing", playing, want.playing);
                    if (want.key_valid)
                        keys_played++;
                end
                results_checked++;
            end
            if (stall_burst_req)
            begin
                stall_left      = BURST_CYCLES;
                stall_burst_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

endmodule
